/* rtl/core/slfr_pkg.sv */
// Shared types and constants for the sync/length frame receiver.
// Used by the controller, the datapath and the top level; no dependencies.
package slfr_pkg;

    localparam logic [7:0] SYNC_BYTE  = 8'hFF;
    localparam int         LEN_LIMIT  = 32;
    localparam int         LEN_W      = 5;

    localparam logic FUNC_BYTE    = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_HUNT1,
        ST_HUNT2,
        ST_LEN,
        ST_CMD,
        ST_DATA,
        ST_HELD,
        ST_SEND_CMD,
        ST_SEND_DATA
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_len;
        logic load_cmd;
        logic store_byte;
        logic clr_rd;
        logic inc_rd;
        logic rd_en;
        logic out_load_cmd;
        logic out_load_data;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_sync;
        logic len_ok;
        logic bl_one;
        logic cmd_last;
        logic data_last;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/core/slfr_ctrl.sv */
// Frame receiver controller: hunts sync bytes, tracks the frame and
// sequences the release. Depends on slfr_pkg.
module slfr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_func,
    output logic              s_ready,
    input  slfr_pkg::dp_stat_t stat,
    output slfr_pkg::dp_cmd_t  cmd
);
    import slfr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   byte_acc;
    logic   rel_acc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT1;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = (state_reg != ST_SEND_CMD) && (state_reg != ST_SEND_DATA)
                     && (state_reg != ST_SEND_DATA);
        byte_acc   = s_valid && s_ready && (s_func == FUNC_BYTE);
        rel_acc    = s_valid && s_ready && (s_func == FUNC_RELEASE);

        unique case (state_reg)
            ST_HUNT1: begin
                if (byte_acc && stat.is_sync) begin
                    state_next = ST_HUNT2;
                end
            end
            ST_HUNT2: begin
                if (byte_acc) begin
                    state_next = stat.is_sync ? ST_LEN : ST_HUNT1;
                end
            end
            ST_LEN: begin
                if (byte_acc) begin
                    if (stat.len_ok) begin
                        cmd.load_len = 1'b1;
                        state_next   = ST_CMD;
                    end else begin
                        state_next = ST_HUNT1;
                    end
                end
            end
            ST_CMD: begin
                if (byte_acc) begin
                    cmd.load_cmd = 1'b1;
                    state_next   = stat.bl_one ? ST_HELD : ST_DATA;
                end
            end
            ST_DATA: begin
                if (byte_acc) begin
                    cmd.store_byte = 1'b1;
                    state_next     = stat.bl_one ? ST_HELD : ST_DATA;
                end
            end
            ST_HELD: begin
                // Received bytes are dropped until the frame is released.
                if (rel_acc) begin
                    state_next = ST_SEND_CMD;
                end
            end
            ST_SEND_CMD: begin
                if (stat.out_free) begin
                    cmd.out_load_cmd = 1'b1;
                    if (stat.cmd_last) begin
                        state_next = ST_HUNT1;
                    end else begin
                        cmd.clr_rd = 1'b1;
                        cmd.rd_en  = 1'b1;
                        state_next = ST_SEND_DATA;
                    end
                end
            end
            ST_SEND_DATA: begin
                if (stat.out_free) begin
                    cmd.out_load_data = 1'b1;
                    if (stat.data_last) begin
                        state_next = ST_HUNT1;
                    end else begin
                        cmd.inc_rd = 1'b1;
                        cmd.rd_en  = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_HUNT1;
            end
        endcase
    end

endmodule

/* rtl/core/slfr_dp.sv */
// Frame receiver datapath: length and index counters, payload store and
// the output register. Depends on slfr_pkg.
module slfr_dp #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  slfr_pkg::dp_cmd_t  cmd,
    output slfr_pkg::dp_stat_t stat,
    input  logic [7:0]         rx_byte,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [7:0]         m_frame_byte,
    output logic               m_is_command,
    output logic               m_last
);
    import slfr_pkg::*;

    // A frame carries at most LEN_LIMIT - 2 payload bytes.
    localparam int MAX_PAYLOAD = LEN_LIMIT - 2;
    localparam int STORE_DEPTH = (BUFFER_BYTES < MAX_PAYLOAD) ? BUFFER_BYTES : MAX_PAYLOAD;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int WCW         = $clog2(STORE_DEPTH + 1);

    logic [7:0]       store_mem [STORE_DEPTH];
    logic [LEN_W-1:0] bytes_left_reg;
    logic [WCW-1:0]   write_index_reg;
    logic [AW-1:0]    rd_idx_reg;
    logic [AW-1:0]    rd_addr;
    logic [7:0]       held_command_reg;
    logic [7:0]       rd_data_reg;
    logic             m_valid_reg;
    logic [7:0]       m_frame_byte_reg;
    logic             m_is_command_reg;
    logic             m_last_reg;
    logic             store_room;
    logic [WCW-1:0]   rd_count;

    assign store_room = write_index_reg < WCW'(STORE_DEPTH);
    assign rd_count   = WCW'(rd_idx_reg) + WCW'(1);
    assign rd_addr    = cmd.clr_rd ? '0 : (rd_idx_reg + AW'(1));

    assign stat.is_sync   = (rx_byte == SYNC_BYTE);
    assign stat.len_ok    = (rx_byte != 8'd0) && (rx_byte < 8'(LEN_LIMIT));
    assign stat.bl_one    = (bytes_left_reg == LEN_W'(1));
    assign stat.cmd_last  = (write_index_reg == '0);
    assign stat.data_last = (rd_count == write_index_reg);
    assign stat.out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg   <= '0;
            write_index_reg  <= '0;
            held_command_reg <= '0;
            rd_idx_reg       <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cmd.load_len) begin
                bytes_left_reg <= rx_byte[LEN_W-1:0];
            end else if (cmd.load_cmd || cmd.store_byte) begin
                bytes_left_reg <= bytes_left_reg - LEN_W'(1);
            end

            if (cmd.load_cmd) begin
                held_command_reg <= rx_byte;
                write_index_reg  <= '0;
            end else if (cmd.store_byte && store_room) begin
                write_index_reg <= write_index_reg + WCW'(1);
            end

            if (cmd.clr_rd || cmd.inc_rd) begin
                rd_idx_reg <= rd_addr;
            end

            if (cmd.out_load_cmd || cmd.out_load_data) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.store_byte && store_room) begin
            store_mem[write_index_reg[AW-1:0]] <= rx_byte;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load_cmd) begin
            m_frame_byte_reg <= held_command_reg;
            m_is_command_reg <= 1'b1;
            m_last_reg       <= stat.cmd_last;
        end else if (cmd.out_load_data) begin
            m_frame_byte_reg <= rd_data_reg;
            m_is_command_reg <= 1'b0;
            m_last_reg       <= stat.data_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_byte = m_frame_byte_reg;
    assign m_is_command = m_is_command_reg;
    assign m_last       = m_last_reg;

endmodule

/* rtl/core/sync_length_frame_receiver.sv */
// Sync/length framed byte stream receiver, top level.
// A received byte item is taken whenever s_ready is high. A release of a held frame
// keeps the input stalled while the frame is sent: the command item enters the output
// register from the send-command state once the output is free, then one payload
// item per cycle while the output is taken; the store's single read port sets this.
// Reset clears the controller, counters and output valid; the store is not cleared.
module sync_length_frame_receiver #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_frame_byte,
    output logic       m_is_command,
    output logic       m_last
);
    import slfr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    slfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    slfr_dp #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .rx_byte      (s_rx_byte),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_frame_byte (m_frame_byte),
        .m_is_command (m_is_command),
        .m_last       (m_last)
    );

    // The output register is only loaded when it is empty or its item is taken in that cycle.
    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load_cmd || cmd.out_load_data) |-> (!m_valid || m_ready))
        else $error("output register overwritten while its item was pending");

    // At most one datapath update of the frame or the output at a time.
    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_len, cmd.load_cmd, cmd.store_byte,
                  cmd.out_load_cmd, cmd.out_load_data}))
        else $error("conflicting datapath commands");

    // No input item is taken while a frame is being sent.
    a_rx_idle_on_send: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(cmd.out_load_cmd || cmd.out_load_data || cmd.rd_en))
        else $error("input accepted during frame release");

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// Testbench for sync_length_frame_receiver: a short directed table, then random framed
// traffic, with released bytes checked against a behavioral deframer or a row's typed expectation.
// Depends on slfr_pkg and the sync_length_frame_receiver RTL.
module tb;
    import slfr_pkg::*;

    localparam int STORE_BYTES = 32;
    localparam int MAX_SHOWN   = 10;
    localparam int RANDOM_ITEMS = 105;

    // How a directed row gets its expectation.
    localparam logic [1:0] CHECK_PRED = 2'd0;
    localparam logic [1:0] TYPED_NONE = 2'd1;
    localparam logic [1:0] TYPED_ONE  = 2'd2;

    typedef struct packed {
        logic [7:0] data;
        logic       cmd;
        logic       fin;
    } frame_out_t;

    typedef struct packed {
        logic       func;
        logic [7:0] b;
        logic [1:0] mode;
        frame_out_t want;
    } stim_row_t;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_func = FUNC_BYTE;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_frame_byte;
    logic       m_is_command;
    logic       m_last;

    // Behavioral deframer state.
    state_t     pr_phase = ST_HUNT1;
    logic [4:0] pr_left = '0;
    logic [4:0] pr_count = '0;
    logic [7:0] pr_cmd = '0;
    logic [7:0] pr_store [STORE_BYTES];

    frame_out_t released_q[$];
    stim_row_t  dir_rows[$];
    int         errors = 0;
    int         sent_items = 0;
    bit         no_idle = 1'b0;

    sync_length_frame_receiver #(.BUFFER_BYTES(STORE_BYTES)) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_is_command (m_is_command),
        .m_last       (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Advances the deframer by one accepted item and, when keep is set, queues the bytes a release sends.
    task automatic deframe_predict(input logic f, input logic [7:0] b, input bit keep);
        frame_out_t r;
        int i;
        if (f == FUNC_BYTE) begin
            case (pr_phase)
                ST_HUNT2: pr_phase = (b == SYNC_BYTE) ? ST_LEN : ST_HUNT1;
                ST_LEN: begin
                    if (b > 0 && b < LEN_LIMIT) begin
                        pr_left  = b[4:0];
                        pr_phase = ST_CMD;
                    end else begin
                        pr_phase = ST_HUNT1;
                    end
                end
                ST_CMD: begin
                    pr_cmd   = b;
                    pr_left  = pr_left - 5'd1;
                    pr_count = '0;
                    pr_phase = (pr_left != 0) ? ST_DATA : ST_HELD;
                end
                ST_DATA: begin
                    if (pr_count < STORE_BYTES) begin
                        pr_store[pr_count] = b;
                        pr_count = pr_count + 5'd1;
                    end
                    pr_left  = pr_left - 5'd1;
                    pr_phase = (pr_left != 0) ? ST_DATA : ST_HELD;
                end
                ST_HELD: ;
                default: pr_phase = (b == SYNC_BYTE) ? ST_HUNT2 : ST_HUNT1;
            endcase
        end else if (pr_phase == ST_HELD) begin
            r.data = pr_cmd;
            r.cmd  = 1'b1;
            r.fin  = (pr_count == 0);
            if (keep) released_q.push_back(r);
            for (i = 0; i < pr_count && i < STORE_BYTES && i < 30; i++) begin
                r.data = pr_store[i];
                r.cmd  = 1'b0;
                r.fin  = (i + 1 == pr_count);
                if (keep) released_q.push_back(r);
            end
            pr_phase = ST_HUNT1;
        end
    endtask

    // Called right after a rising edge; returns right after the edge that took the item.
    task automatic send_item(input logic f, input logic [7:0] b, input logic [1:0] mode,
                             input frame_out_t want);
        while (!no_idle && $urandom_range(0, 99) < 22) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= f;
        s_rx_byte <= b;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        sent_items++;
        deframe_predict(f, b, mode == CHECK_PRED);
        if (mode == TYPED_ONE) released_q.push_back(want);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(FUNC_BYTE, b, CHECK_PRED, '0);
    endtask

    task automatic send_release();
        send_item(FUNC_RELEASE, 8'($urandom), CHECK_PRED, '0);
    endtask

    task automatic send_frame(input int len);
        int k;
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(8'(len));
        for (k = 0; k < len; k++) send_byte(8'($urandom));
    endtask

    task automatic add_row(input logic f, input logic [7:0] b, input logic [1:0] mode,
                           input logic [7:0] d, input logic c, input logic l);
        stim_row_t r;
        r.func = f;
        r.b    = b;
        r.mode = mode;
        r.want = '{data: d, cmd: c, fin: l};
        dir_rows.push_back(r);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (released_q.size() != 0);
    endtask

    initial begin
        int round;
        int pick;
        int len;
        // A release with no frame held sends nothing.
        add_row(FUNC_RELEASE, 8'h00, TYPED_NONE, 8'h00, 1'b0, 1'b0);
        // A length-one frame releases only its command byte, marked as last.
        add_row(FUNC_BYTE, 8'hFF, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_BYTE, 8'hFF, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_BYTE, 8'h01, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_BYTE, 8'hA5, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_RELEASE, 8'h3C, TYPED_ONE, 8'hA5, 1'b1, 1'b1);
        // Bad second sync byte, then lengths of zero and 32.
        add_row(FUNC_BYTE, 8'hFF, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_BYTE, 8'h00, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_BYTE, 8'hFF, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_BYTE, 8'hFF, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_BYTE, 8'h00, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_BYTE, 8'hFF, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_BYTE, 8'hFF, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_BYTE, 8'h20, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_RELEASE, 8'hFF, TYPED_NONE, 8'h00, 1'b0, 1'b0);
        // A three-byte frame with extreme byte values, a byte dropped while held.
        add_row(FUNC_BYTE, 8'hFF, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_BYTE, 8'hFF, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_BYTE, 8'h03, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_BYTE, 8'h00, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_BYTE, 8'hFF, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_BYTE, 8'h00, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_BYTE, 8'hAA, CHECK_PRED, 8'h00, 1'b0, 1'b0);
        add_row(FUNC_RELEASE, 8'hFF, CHECK_PRED, 8'h00, 1'b0, 1'b0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].func, dir_rows[i].b, dir_rows[i].mode, dir_rows[i].want);

        round = 0;
        while (sent_items < dir_rows.size() + RANDOM_ITEMS) begin
            no_idle = (round >= 12 && round < 20);
            pick = $urandom_range(0, 99);
            if (round == 0 || pick < 70) begin
                len = (round == 0 || $urandom_range(0, 9) == 0) ? 31 : $urandom_range(1, 8);
                send_frame(len);
                repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
                send_release();
                // Once, hold the sender off until the full release has drained.
                if (round == 0) wait_drained();
            end else if (pick < 85) begin
                send_byte(SYNC_BYTE);
                if ($urandom_range(0, 1)) begin
                    send_byte(8'($urandom_range(0, 254)));
                end else begin
                    send_byte(SYNC_BYTE);
                    send_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(32, 255)));
                end
            end else if ($urandom_range(0, 1)) begin
                send_release();
            end else begin
                send_byte(8'($urandom));
            end
            round++;
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (20) @(posedge aclk);
        if (errors == 0 && released_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Result side: checks each taken item, then picks the next ready level.
    always @(posedge aclk) begin
        frame_out_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (released_q.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("Unexpected output item: byte %02h cmd %b last %b",
                             m_frame_byte, m_is_command, m_last);
            end else begin
                want = released_q.pop_front();
                if (m_frame_byte !== want.data || m_is_command !== want.cmd ||
                    m_last !== want.fin) begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("Mismatch: expected byte %02h cmd %b last %b, got %02h %b %b",
                                 want.data, want.cmd, want.fin,
                                 m_frame_byte, m_is_command, m_last);
                end
            end
        end
        m_ready <= no_idle || ($urandom_range(0, 99) >= 22);
    end

endmodule

/* sim.f */
rtl/core/slfr_pkg.sv
rtl/core/slfr_ctrl.sv
rtl/core/slfr_dp.sv
rtl/core/sync_length_frame_receiver.sv
verif/tb.sv
